// File: hw/rtl/strict_base64_decoder_defines.svh
// Assertion macros for the strict base64 decoder.
`ifndef STRICT_BASE64_DECODER_DEFINES_SVH
`define STRICT_BASE64_DECODER_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SBD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/sbd_pkg.sv
// Shared types, constants and the alphabet decode for the strict base64 decoder.
package sbd_pkg;

    // Command queue geometry
    localparam int QDepth = 4;
    localparam int PtrW   = $clog2(QDepth);
    localparam int CntW   = $clog2(QDepth + 1);

    // Special characters and alphabet offsets
    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [5:0] SEXT_LO_A  = 6'd26;
    localparam logic [5:0] SEXT_ZERO  = 6'd52;
    localparam logic [5:0] SEXT_PLUS  = 6'd62;
    localparam logic [5:0] SEXT_SLASH = 6'd63;

    // Byte counts carried by a data command
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;
    localparam logic [1:0] CNT_THREE = 2'd3;

    // Decoded alphabet character
    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } t_sextet;

    // One command from the front to the back: up to three bytes or a status
    typedef struct packed {
        logic        is_status;
        logic        status;
        logic [1:0]  count;
        logic [23:0] bytes;
    } t_cmd;

    // Queue fill status
    typedef struct packed {
        logic            full;
        logic            empty;
        logic [CntW-1:0] count;
    } t_q_stat;

    // Map an ASCII character onto its sextet; '=' and others are not valid
    function automatic t_sextet sextet_of(input logic [7:0] ch);
        t_sextet    res;
        logic [7:0] diff;
        res  = '0;
        diff = '0;
        case (ch) inside
            [CHAR_UP_A:CHAR_UP_Z]: begin
                diff      = ch - CHAR_UP_A;
                res.valid = 1'b1;
                res.value = diff[5:0];
            end
            [CHAR_LO_A:CHAR_LO_Z]: begin
                diff      = ch - CHAR_LO_A;
                res.valid = 1'b1;
                res.value = diff[5:0] + SEXT_LO_A;
            end
            [CHAR_ZERO:CHAR_NINE]: begin
                diff      = ch - CHAR_ZERO;
                res.valid = 1'b1;
                res.value = diff[5:0] + SEXT_ZERO;
            end
            CHAR_PLUS: begin
                res.valid = 1'b1;
                res.value = SEXT_PLUS;
            end
            CHAR_SLASH: begin
                res.valid = 1'b1;
                res.value = SEXT_SLASH;
            end
            default: begin
                res = '0;
            end
        endcase
        return res;
    endfunction

endpackage

// File: hw/rtl/strict_base64_decoder.sv
// A group's first byte or status passes through the command queue and a back-end register.
// Throughput: one character per cycle in, one result per cycle out while i_ready is high;
// the front stalls only when the four-entry command queue is full, which the back drains in order.
// Reset: synchronous, active low; clears group state, queue pointers and output valid.
// No clearing pass is needed; the block accepts a character in the first cycle after reset.
`include "strict_base64_decoder_defines.svh"

module strict_base64_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_kind,
    input  logic [7:0] i_symbol,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data_byte,
    output logic       o_is_status,
    output logic       o_status,
    output logic       o_last
);

    sbd_pkg::t_q_stat w_q_stat;
    sbd_pkg::t_cmd    w_push_cmd;
    sbd_pkg::t_cmd    w_head_cmd;
    logic             w_push;
    logic             w_pop;

    // Classify characters
    sbd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_kind   (i_kind),
        .i_symbol (i_symbol),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    // Decouple the two sides
    sbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_stat  (w_q_stat)
    );

    // Emit results
    sbd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (w_q_stat),
        .i_cmd       (w_head_cmd),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data_byte (o_data_byte),
        .o_is_status (o_is_status),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    // An accepted end item always leaves a command waiting in the queue
    `SBD_ASSERT_NEXT(a_end_queued, i_clk, i_rst_n, i_valid && o_ready && i_kind, !w_q_stat.empty, "end item lost before queue")
    // The fill count never passes the queue depth
    `SBD_ASSERT_SAME(a_q_bound, i_clk, i_rst_n, 1'b1, w_q_stat.count <= sbd_pkg::CntW'(sbd_pkg::QDepth), "queue overfilled")
    // Byte results never carry a bad status
    `SBD_ASSERT_SAME(a_byte_clean, i_clk, i_rst_n, o_valid && !o_is_status, !o_status && !o_last, "status bits on a byte result")

endmodule

// File: hw/rtl/sbd_front.sv
// Front end: accepts characters, checks the strict rules and issues byte or status commands.
module sbd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_kind,
    input  logic [7:0]     i_symbol,
    input  sbd_pkg::t_q_stat i_q_stat,
    output logic           o_push,
    output sbd_pkg::t_cmd  o_cmd
);

    logic [1:0]  r_pos,   n_pos;
    logic [17:0] r_held,  n_held;
    logic        r_pad,   n_pad;
    logic        r_any,   n_any;
    logic        r_pdone, n_pdone;
    logic        r_err,   n_err;

    sbd_pkg::t_sextet w_sext;
    logic             w_is_pad;
    logic             w_acc;
    logic             w_err3;
    logic [5:0]       w_d;

    // Accept whenever the queue has room
    assign o_ready  = !i_q_stat.full;
    assign w_acc    = i_valid && o_ready;
    assign w_sext   = sbd_pkg::sextet_of(i_symbol);
    assign w_is_pad = (i_symbol == sbd_pkg::PAD_CHAR);
    assign w_d      = w_is_pad ? 6'd0 : w_sext.value;

    // Final character of a group: padding must match what came before
    always_comb begin
        if (r_pad) begin
            w_err3 = !w_is_pad;
        end else if (w_is_pad) begin
            w_err3 = (r_held[1:0] != 2'd0);
        end else begin
            w_err3 = !w_sext.valid;
        end
    end

    // Advance the group state and build the command
    always_comb begin
        n_pos   = r_pos;
        n_held  = r_held;
        n_pad   = r_pad;
        n_any   = r_any;
        n_pdone = r_pdone;
        n_err   = r_err;
        o_push  = 1'b0;
        o_cmd   = '0;
        if (w_acc) begin
            if (i_kind) begin
                // End of sequence: report and return to the reset state
                o_push          = 1'b1;
                o_cmd.is_status = 1'b1;
                o_cmd.status    = r_err || !r_any || (r_pos != 2'd0);
                n_pos   = '0;
                n_held  = '0;
                n_pad   = 1'b0;
                n_any   = 1'b0;
                n_pdone = 1'b0;
                n_err   = 1'b0;
            end else begin
                n_any = 1'b1;
                if (r_err) begin
                    // Drop characters after an error
                    n_err = 1'b1;
                end else if (r_pdone) begin
                    n_err = 1'b1;
                end else begin
                    case (r_pos)
                        2'd0, 2'd1: begin
                            if (!w_sext.valid) begin
                                n_err = 1'b1;
                            end else begin
                                n_held = {r_held[11:0], w_sext.value};
                                n_pos  = r_pos + 2'd1;
                            end
                        end
                        2'd2: begin
                            if (w_is_pad) begin
                                if (r_held[3:0] != 4'd0) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_pad  = 1'b1;
                                    n_held = {r_held[11:0], 6'd0};
                                    n_pos  = 2'd3;
                                end
                            end else if (!w_sext.valid) begin
                                n_err = 1'b1;
                            end else begin
                                n_held = {r_held[11:0], w_sext.value};
                                n_pos  = 2'd3;
                            end
                        end
                        default: begin
                            if (w_err3) begin
                                n_err = 1'b1;
                            end else begin
                                o_push      = 1'b1;
                                o_cmd.bytes = {r_held, w_d};
                                if (r_pad) begin
                                    o_cmd.count = sbd_pkg::CNT_ONE;
                                end else if (w_is_pad) begin
                                    o_cmd.count = sbd_pkg::CNT_TWO;
                                end else begin
                                    o_cmd.count = sbd_pkg::CNT_THREE;
                                end
                                n_pdone = w_is_pad;
                                n_pos   = '0;
                                n_held  = '0;
                                n_pad   = 1'b0;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // Hold the group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_held  <= '0;
            r_pad   <= 1'b0;
            r_any   <= 1'b0;
            r_pdone <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_held  <= n_held;
            r_pad   <= n_pad;
            r_any   <= n_any;
            r_pdone <= n_pdone;
            r_err   <= n_err;
        end
    end

endmodule

// File: hw/rtl/sbd_queue.sv
// Short command queue between the front and the back.
module sbd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sbd_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output sbd_pkg::t_cmd    o_cmd,
    output sbd_pkg::t_q_stat o_stat
);

    sbd_pkg::t_cmd r_mem [sbd_pkg::QDepth];

    logic [sbd_pkg::PtrW-1:0] r_wr, n_wr;
    logic [sbd_pkg::PtrW-1:0] r_rd, n_rd;
    logic [sbd_pkg::CntW-1:0] r_cnt, n_cnt;

    assign o_cmd        = r_mem[r_rd];
    assign o_stat.count = r_cnt;
    assign o_stat.full  = (r_cnt == sbd_pkg::CntW'(sbd_pkg::QDepth));
    assign o_stat.empty = (r_cnt == '0);

    // Advance pointers and fill count
    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_pop  ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Store a pushed command
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: hw/rtl/sbd_back.sv
// Back end: unpacks queued commands into one result transfer per cycle while i_ready is high.
module sbd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sbd_pkg::t_q_stat i_q_stat,
    input  sbd_pkg::t_cmd    i_cmd,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_data_byte,
    output logic             o_is_status,
    output logic             o_status,
    output logic             o_last
);

    logic        r_busy,   n_busy;
    logic [23:0] r_bytes,  n_bytes;
    logic [1:0]  r_left,   n_left;
    logic        r_is_st,  n_is_st;
    logic        r_status, n_status;

    logic w_take;
    logic w_finish;

    assign o_valid     = r_busy;
    assign o_data_byte = r_is_st ? 8'd0 : r_bytes[23:16];
    assign o_is_status = r_is_st;
    assign o_status    = r_status;
    assign o_last      = r_is_st;

    assign w_take   = r_busy && i_ready;
    assign w_finish = w_take && (r_is_st || (r_left == sbd_pkg::CNT_ONE));

    // Load the next command or step through the current one
    always_comb begin
        n_busy   = r_busy;
        n_bytes  = r_bytes;
        n_left   = r_left;
        n_is_st  = r_is_st;
        n_status = r_status;
        o_pop    = 1'b0;
        if (!r_busy || w_finish) begin
            if (!i_q_stat.empty) begin
                o_pop    = 1'b1;
                n_busy   = 1'b1;
                n_bytes  = i_cmd.bytes;
                n_left   = i_cmd.count;
                n_is_st  = i_cmd.is_status;
                n_status = i_cmd.status;
            end else begin
                n_busy = 1'b0;
            end
        end else if (w_take) begin
            n_bytes = {r_bytes[15:0], 8'd0};
            n_left  = r_left - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        r_bytes  <= n_bytes;
        r_left   <= n_left;
        r_is_st  <= n_is_st;
        r_status <= n_status;
    end

endmodule

// File: test/tb_strict_base64_decoder.sv
// Self-checking testbench for the strict base64 decoder: directed streams, then random ones.
module tb_strict_base64_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned RANDOM_ITEMS = 105;

    localparam logic KIND_CHAR  = 1'b0;
    localparam logic KIND_END   = 1'b1;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    // Ways of breaking an otherwise well-formed stream
    typedef enum int unsigned {
        CORRUPT_SWAP,
        CORRUPT_DROP,
        CORRUPT_TAIL,
        CORRUPT_PAD
    } corrupt_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_status;
        logic       status;
        logic       is_last;
    } decode_out_t;

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       i_valid  = 1'b0;
    logic       i_kind   = 1'b0;
    logic [7:0] i_symbol = 8'h00;
    logic       i_ready  = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_data_byte;
    logic       o_is_status;
    logic       o_status;
    logic       o_last;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned cycle_count   = 0;
    int unsigned fail_count    = 0;
    int unsigned items_sent    = 0;

    // Decoded bytes and status results still owed by the block, oldest first
    decode_out_t decode_queue[$];

    // Decoder state as predicted
    logic [1:0]  grp_pos;
    logic [17:0] held;
    logic [1:0]  pad_seen;
    logic        char_seen;
    logic        pad_group_done;
    logic        sticky_err;

    strict_base64_decoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_symbol    (i_symbol),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data_byte (o_data_byte),
        .o_is_status (o_is_status),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    // Toggle the clock
    always #5 i_clk = ~i_clk;

    // End the run if it hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, decode_queue.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Stall the result channel at random
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
            fail_count++;
        end
    endtask

    // Compare each result transfer with the oldest owed result
    always @(posedge i_clk) begin : check_results
        decode_out_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (decode_queue.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual byte %0h status %0b/%0b last %0b",
                         $time, o_data_byte, o_is_status, o_status, o_last);
                fail_count++;
            end else begin
                want = decode_queue.pop_front();
                check_field("data_byte", want.data_byte, o_data_byte);
                check_field("is_status", {7'd0, want.is_status}, {7'd0, o_is_status});
                check_field("status", {7'd0, want.status}, {7'd0, o_status});
                check_field("last", {7'd0, want.is_last}, {7'd0, o_last});
            end
        end
    end

    // Sextet of an alphabet character, with bit 6 set when the character is valid
    function automatic logic [6:0] alphabet_value(input logic [7:0] c);
        logic [7:0] off;
        off = 8'h00;
        if (c >= sbd_pkg::CHAR_UP_A && c <= sbd_pkg::CHAR_UP_Z) begin
            off = c - sbd_pkg::CHAR_UP_A;
            return {1'b1, off[5:0]};
        end
        if (c >= sbd_pkg::CHAR_LO_A && c <= sbd_pkg::CHAR_LO_Z) begin
            off = c - sbd_pkg::CHAR_LO_A;
            return {1'b1, off[5:0] + sbd_pkg::SEXT_LO_A};
        end
        if (c >= sbd_pkg::CHAR_ZERO && c <= sbd_pkg::CHAR_NINE) begin
            off = c - sbd_pkg::CHAR_ZERO;
            return {1'b1, off[5:0] + sbd_pkg::SEXT_ZERO};
        end
        if (c == sbd_pkg::CHAR_PLUS) return {1'b1, sbd_pkg::SEXT_PLUS};
        if (c == sbd_pkg::CHAR_SLASH) return {1'b1, sbd_pkg::SEXT_SLASH};
        return 7'd0;
    endfunction

    // Character that encodes a sextet
    function automatic logic [7:0] alphabet_char(input logic [5:0] v);
        if (v < sbd_pkg::SEXT_LO_A) return sbd_pkg::CHAR_UP_A + v;
        if (v < sbd_pkg::SEXT_ZERO) return sbd_pkg::CHAR_LO_A + (v - sbd_pkg::SEXT_LO_A);
        if (v < sbd_pkg::SEXT_PLUS) return sbd_pkg::CHAR_ZERO + (v - sbd_pkg::SEXT_ZERO);
        if (v == sbd_pkg::SEXT_PLUS) return sbd_pkg::CHAR_PLUS;
        return sbd_pkg::CHAR_SLASH;
    endfunction

    function automatic void clear_decoder_state();
        grp_pos        = 2'd0;
        held           = 18'd0;
        pad_seen       = 2'd0;
        char_seen      = 1'b0;
        pad_group_done = 1'b0;
        sticky_err     = 1'b0;
    endfunction

    function automatic void owe_result(input logic [7:0] data, input logic is_st,
                                       input logic st, input logic lst);
        decode_queue.push_back({data, is_st, st, lst});
    endfunction

    // Advance the predicted decoder by one accepted item
    task automatic decode_transfer(input logic kind, input logic [7:0] sym);
        logic [6:0] sx;
        logic [5:0] a;
        logic [5:0] b;
        logic [5:0] c;
        logic [5:0] d;
        logic       is_pad;
        if (kind == KIND_END) begin
            owe_result(8'h00, 1'b1,
                       (sticky_err || !char_seen || grp_pos != 2'd0) ? STATUS_BAD : STATUS_OK,
                       1'b1);
            clear_decoder_state();
            return;
        end
        char_seen = 1'b1;
        if (sticky_err) return;
        if (pad_group_done) begin
            sticky_err = 1'b1;
            return;
        end
        is_pad = (sym == sbd_pkg::PAD_CHAR);
        sx     = alphabet_value(sym);
        case (grp_pos)
            2'd0, 2'd1: begin
                if (!sx[6]) begin
                    sticky_err = 1'b1;
                end else begin
                    held    = {held[11:0], sx[5:0]};
                    grp_pos = grp_pos + 2'd1;
                end
            end
            2'd2: begin
                if (is_pad) begin
                    // Padding here needs the low four bits of the second sextet clear
                    if (held[3:0] != 4'd0) begin
                        sticky_err = 1'b1;
                    end else begin
                        pad_seen = 2'd1;
                        held     = {held[11:0], 6'd0};
                        grp_pos  = 2'd3;
                    end
                end else if (!sx[6]) begin
                    sticky_err = 1'b1;
                end else begin
                    held    = {held[11:0], sx[5:0]};
                    grp_pos = 2'd3;
                end
            end
            default: begin
                if (pad_seen != 2'd0 && !is_pad) begin
                    sticky_err = 1'b1;
                end else if (pad_seen == 2'd0 && is_pad && held[1:0] != 2'd0) begin
                    sticky_err = 1'b1;
                end else if (!is_pad && !sx[6]) begin
                    sticky_err = 1'b1;
                end else begin
                    // Group complete: emit one, two or three bytes
                    a = held[17:12];
                    b = held[11:6];
                    c = held[5:0];
                    d = is_pad ? 6'd0 : sx[5:0];
                    owe_result({a, b[5:4]}, 1'b0, STATUS_OK, 1'b0);
                    if (pad_seen == 2'd0) owe_result({b[3:0], c[5:2]}, 1'b0, STATUS_OK, 1'b0);
                    if (!is_pad) owe_result({c[1:0], d}, 1'b0, STATUS_OK, 1'b0);
                    if (is_pad) pad_group_done = 1'b1;
                    grp_pos  = 2'd0;
                    held     = 18'd0;
                    pad_seen = 2'd0;
                end
            end
        endcase
    endtask

    // Offer one item, idling at random first, and hold it until the transfer
    task automatic send_item(input logic kind, input logic [7:0] sym);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_kind   <= kind;
        i_symbol <= sym;
        do @(posedge i_clk); while (!o_ready);
        decode_transfer(kind, sym);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Send a text as characters, then an end item
    task automatic send_stream(input string s);
        for (int i = 0; i < s.len(); i++) send_item(KIND_CHAR, s[i]);
        send_item(KIND_END, 8'($urandom_range(255)));
    endtask

    // Hold the input idle until every owed result has arrived
    task automatic pause_until_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (decode_queue.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_full_groups();
        send_stream("Az09+/AA");
    endtask

    task automatic test_padding();
        send_stream("QQ==");
        send_stream("QUI=");
    endtask

    task automatic test_bad_padding();
        send_stream("=");
        send_stream("A=");
        send_stream("QQ=A");
        send_stream("QQ==A");
    endtask

    task automatic test_leftover_bits();
        send_stream("QR==");
        send_stream("QUJ=");
    endtask

    // Non-alphabet characters at both ends of the byte range; later characters are swallowed
    task automatic test_bad_characters();
        send_item(KIND_CHAR, 8'hFF);
        send_item(KIND_CHAR, sbd_pkg::CHAR_UP_A);
        send_item(KIND_END, 8'h00);
        send_item(KIND_CHAR, 8'h00);
        send_item(KIND_END, 8'hFF);
    endtask

    task automatic test_framing();
        send_item(KIND_END, 8'hFF);
        send_stream("QUJ");
    endtask

    // One random stream: mostly well formed, now and then broken
    task automatic send_random_stream();
        logic [7:0]  chars[$];
        int unsigned groups;
        int unsigned pads;
        int unsigned spot;
        corrupt_t    mode;
        groups = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
        pads   = $urandom_range(2);
        for (int g = 0; g < groups; g++) begin
            if (g == groups - 1 && pads == 2) begin
                chars.push_back(alphabet_char(6'($urandom_range(63))));
                chars.push_back(alphabet_char({2'($urandom_range(3)), 4'b0000}));
                chars.push_back(sbd_pkg::PAD_CHAR);
                chars.push_back(sbd_pkg::PAD_CHAR);
            end else if (g == groups - 1 && pads == 1) begin
                chars.push_back(alphabet_char(6'($urandom_range(63))));
                chars.push_back(alphabet_char(6'($urandom_range(63))));
                chars.push_back(alphabet_char({4'($urandom_range(15)), 2'b00}));
                chars.push_back(sbd_pkg::PAD_CHAR);
            end else begin
                repeat (4) chars.push_back(alphabet_char(6'($urandom_range(63))));
            end
        end
        // Break one stream in five
        if ($urandom_range(4) == 0) begin
            mode = corrupt_t'($urandom_range(3));
            spot = (chars.size() == 0) ? 0 : $urandom_range(chars.size() - 1);
            case (mode)
                CORRUPT_SWAP: begin
                    if (chars.size() != 0) chars[spot] = 8'($urandom_range(255));
                    else chars.push_back(8'($urandom_range(255)));
                end
                CORRUPT_DROP: begin
                    if (chars.size() != 0) chars.delete(spot);
                end
                CORRUPT_TAIL: begin
                    chars.push_back(alphabet_char(6'($urandom_range(63))));
                end
                default: begin
                    chars.insert(spot, sbd_pkg::PAD_CHAR);
                end
            endcase
        end
        foreach (chars[i]) send_item(KIND_CHAR, chars[i]);
        send_item(KIND_END, 8'($urandom_range(255)));
    endtask

    // Random streams mixed with stray items of any kind and value
    task automatic test_random_streams(input int unsigned n_items);
        int unsigned stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 10) begin
                send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
            end else begin
                send_random_stream();
            end
            if ($urandom_range(99) < 8) pause_until_drained();
        end
    endtask

    initial begin
        clear_decoder_state();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Sender idles lightly, receiver heavily
        send_idle_pct = 12;
        recv_idle_pct = 67;
        test_full_groups();
        test_padding();
        test_bad_padding();
        test_leftover_bits();
        test_bad_characters();
        test_framing();
        test_random_streams(RANDOM_ITEMS / 3);
        pause_until_drained();

        // Swap the idling
        send_idle_pct = 67;
        recv_idle_pct = 12;
        test_random_streams(RANDOM_ITEMS / 3);
        pause_until_drained();

        // Full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_streams(RANDOM_ITEMS / 3);
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
